// ===== hw/rtl/u16u8_pkg.sv =====
// u16u8_pkg: shared types, constants and the code point encoder
// for the utf-16 to utf-8 transcoder; no dependencies
`timescale 1ns / 1ps

package u16u8_pkg;

    localparam logic [15:0] HI_SUR_MIN = 16'hD800;
    localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
    localparam logic [15:0] BOM_UNIT   = 16'hFEFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;
    localparam logic [20:0] CP_MAX_1B  = 21'h7F;
    localparam logic [20:0] CP_MAX_2B  = 21'h7FF;
    localparam logic [20:0] CP_MAX_3B  = 21'hFFFF;
    localparam int          MAX_BYTES  = 6;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last_of_run;
        logic       end_of_text;
    } t_out_item;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } t_enc;

    // all bytes caused by one input transfer
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                cnt;
        logic                      marker;
        logic                      eot;
    } t_burst;

    function automatic t_enc enc_cp(input logic [20:0] cp);
        t_enc e;
        e.bytes = '0;
        if (cp <= CP_MAX_1B) begin
            e.bytes[0] = cp[7:0];
            e.len      = 3'd1;
        end else if (cp <= CP_MAX_2B) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.len      = 3'd2;
        end else if (cp <= CP_MAX_3B) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.len      = 3'd3;
        end else begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.len      = 3'd4;
        end
        return e;
    endfunction

endpackage

// ===== hw/rtl/utf16_to_utf8_transcoder_top.sv =====
// utf16 to utf8 transcoder: byte order register, decode stage, byte serializer
// each input byte is registered in the decode stage and its burst in the serializer buffer before output
// throughput: one input byte per cycle unless a burst waits for the serializer
// an item with n result bytes holds the serializer until all n bytes have transferred, which sets the rate
// synchronous active-low reset clears all text state and selects low byte first
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_top
    import u16u8_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic   r_le_order;
    logic   burst_valid;
    logic   burst_ready;
    t_burst burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_le_order <= 1'b1;
        end else if (i_cfg_we) begin
            r_le_order <= i_cfg_wdata;
        end
    end

    u16u8_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_le_order    (r_le_order),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .o_burst_valid (burst_valid),
        .o_burst       (burst),
        .i_burst_ready (burst_ready)
    );

    u16u8_serial u_serial (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_burst_valid (burst_valid),
        .i_burst       (burst),
        .o_burst_ready (burst_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_item    (o_out_item)
    );

endmodule

// ===== hw/rtl/u16u8_decode.sv =====
// u16u8_decode: input register, text state and unit decode into a byte burst
// depends on u16u8_pkg
`timescale 1ns / 1ps

module u16u8_decode
    import u16u8_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_le_order,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_burst_valid,
    output t_burst   o_burst,
    input  logic     i_burst_ready
);

    logic       r_vld;
    t_in_item   r_item;
    logic [7:0] r_held_byte;
    logic       r_half_unit;
    logic       r_at_start;
    logic [9:0] r_pend_bits;
    logic       r_pend_vld;

    logic [7:0] n_held_byte;
    logic       n_half_unit;
    logic       n_at_start;
    logic [9:0] n_pend_bits;
    logic       n_pend_vld;

    logic [15:0] unit;
    logic        has_unit;
    logic        is_low;
    logic        is_high;
    logic        last;
    logic        use1;
    logic        use2;
    logic [20:0] cp1;
    logic [20:0] cp2;
    t_enc        e1;
    t_enc        e2;
    logic [2:0]  len1;
    logic [2:0]  len2;
    logic        empty;
    logic        move;

    assign last = r_item.end_of_input;
    assign unit = i_le_order ? {r_item.in_byte, r_held_byte}
                             : {r_held_byte, r_item.in_byte};
    assign has_unit = r_half_unit && !(r_at_start && unit == BOM_UNIT);
    assign is_low   = unit inside {[LO_SUR_MIN:LO_SUR_MAX]};
    assign is_high  = unit inside {[HI_SUR_MIN:HI_SUR_MAX]};

    always_comb begin
        use1 = 1'b0;
        use2 = 1'b0;
        cp1  = {5'd0, HI_SUR_MIN[15:10], r_pend_bits};
        cp2  = {5'd0, HI_SUR_MIN[15:10], r_pend_bits};
        if (!has_unit) begin
            use2 = last && r_pend_vld;
        end else if (r_pend_vld && is_low) begin
            use1 = 1'b1;
            cp1  = SUPP_BASE + {1'b0, r_pend_bits, unit[9:0]};
        end else begin
            use1 = r_pend_vld;
            use2 = !is_high || last;
            cp2  = {5'd0, unit};
        end
    end

    assign e1   = enc_cp(cp1);
    assign e2   = enc_cp(cp2);
    assign len1 = use1 ? e1.len : 3'd0;
    assign len2 = use2 ? e2.len : 3'd0;

    always_comb begin
        o_burst.bytes = '0;
        for (int k = 0; k < MAX_BYTES; k++) begin
            logic [2:0] off;
            off = 3'(k) - len1;
            if (3'(k) < len1) begin
                o_burst.bytes[k] = e1.bytes[2'(k)];
            end else if (off < len2) begin
                o_burst.bytes[k] = e2.bytes[off[1:0]];
            end
        end
        o_burst.cnt    = len1 + len2;
        o_burst.marker = last && (len1 + len2 == 3'd0);
        o_burst.eot    = last;
    end

    assign empty         = (o_burst.cnt == 3'd0) && !o_burst.marker;
    assign move          = r_vld && (empty || i_burst_ready);
    assign o_burst_valid = r_vld && !empty;
    assign o_in_ready    = !r_vld || move;

    always_comb begin
        n_held_byte = r_held_byte;
        n_half_unit = r_half_unit;
        n_at_start  = r_at_start;
        n_pend_bits = r_pend_bits;
        n_pend_vld  = r_pend_vld;
        if (last) begin
            n_held_byte = '0;
            n_half_unit = 1'b0;
            n_at_start  = 1'b1;
            n_pend_bits = '0;
            n_pend_vld  = 1'b0;
        end else if (!r_half_unit) begin
            n_held_byte = r_item.in_byte;
            n_half_unit = 1'b1;
        end else begin
            n_held_byte = '0;
            n_half_unit = 1'b0;
            n_at_start  = 1'b0;
            if (has_unit) begin
                if (!(r_pend_vld && is_low) && is_high) begin
                    n_pend_bits = unit[9:0];
                    n_pend_vld  = 1'b1;
                end else begin
                    n_pend_bits = '0;
                    n_pend_vld  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= 1'b0;
            r_held_byte <= '0;
            r_half_unit <= 1'b0;
            r_at_start  <= 1'b1;
            r_pend_bits <= '0;
            r_pend_vld  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_vld <= i_in_valid;
            end
            if (move) begin
                r_held_byte <= n_held_byte;
                r_half_unit <= n_half_unit;
                r_at_start  <= n_at_start;
                r_pend_bits <= n_pend_bits;
                r_pend_vld  <= n_pend_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_in_item;
        end
    end

    // pending high surrogate only exists between units
    a_pend_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> !r_at_start)
        else $error("pending surrogate at text start");

    a_burst_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_burst_valid |-> (o_burst.cnt <= 3'(MAX_BYTES)))
        else $error("burst longer than six bytes");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && last |=> r_at_start && !r_half_unit && !r_pend_vld)
        else $error("text state not cleared after final byte");

endmodule

// ===== hw/rtl/u16u8_serial.sv =====
// u16u8_serial: burst buffer that hands out one utf-8 byte, or an end marker with no byte, per transfer
// depends on u16u8_pkg
`timescale 1ns / 1ps

module u16u8_serial
    import u16u8_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_burst_valid,
    input  t_burst    i_burst,
    output logic      o_burst_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic       r_vld;
    t_burst     r_buf;
    logic [2:0] r_idx;
    logic       at_last;
    logic       fire;

    assign at_last       = r_buf.marker || (r_idx == r_buf.cnt - 3'd1);
    assign fire          = r_vld && i_out_ready;
    assign o_burst_ready = !r_vld || (fire && at_last);
    assign o_out_valid   = r_vld;

    always_comb begin
        o_out_item.out_byte    = r_buf.marker ? 8'd0 : r_buf.bytes[r_idx];
        o_out_item.has_byte    = !r_buf.marker;
        o_out_item.last_of_run = at_last;
        o_out_item.end_of_text = at_last && r_buf.eot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (o_burst_ready) begin
            r_vld <= i_burst_valid;
            r_idx <= '0;
        end else if (fire) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_burst_ready && i_burst_valid) begin
            r_buf <= i_burst;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_buf.marker |-> (r_buf.cnt != 3'd0) && (r_idx < r_buf.cnt))
        else $error("byte index outside burst");

    a_marker_eot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_buf.marker |-> r_buf.eot && r_idx == 3'd0)
        else $error("end marker without end of text");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !at_last |=> r_vld && r_idx == $past(r_idx) + 3'd1)
        else $error("burst advanced incorrectly");

endmodule

// ===== dv/utf16_to_utf8_transcoder_top_tb.sv =====
// utf16_to_utf8_transcoder_top_tb: self-checking testbench for the utf-16 to utf-8 transcoder
// drives byte transfers with random gaps, predicts utf-8 results and compares each one
// depends on u16u8_pkg and utf16_to_utf8_transcoder_top
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_top_tb;
    import u16u8_pkg::*;

    localparam int IDLE_PCT     = 32;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 40;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // predictor state
    logic       order_le   = 1'b1;
    logic [7:0] pend_byte  = '0;
    logic       byte_held  = 1'b0;
    logic       text_fresh = 1'b1;
    logic [9:0] hi_bits    = '0;
    logic       hi_waiting = 1'b0;

    logic [7:0] step_bytes [$];
    t_out_item  utf8_expected [$];
    t_in_item   utf16_bytes [$];

    int  items_queued = 0;
    int  mismatches   = 0;
    int  stall_cycles = 0;
    int  hold_left    = 0;
    bit  calm         = 1'b0;
    bit  hold_req     = 1'b0;
    bit  hold_done    = 1'b0;

    utf16_to_utf8_transcoder_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    function automatic void push_code_point(input logic [20:0] cp);
        if (cp <= 21'h7F) begin
            step_bytes = {step_bytes, cp[7:0]};
        end else if (cp <= 21'h7FF) begin
            step_bytes = {step_bytes, 8'hC0 | {3'd0, cp[10:6]}};
            step_bytes = {step_bytes, 8'h80 | {2'd0, cp[5:0]}};
        end else if (cp <= 21'hFFFF) begin
            step_bytes = {step_bytes, 8'hE0 | {4'd0, cp[15:12]}};
            step_bytes = {step_bytes, 8'h80 | {2'd0, cp[11:6]}};
            step_bytes = {step_bytes, 8'h80 | {2'd0, cp[5:0]}};
        end else begin
            step_bytes = {step_bytes, 8'hF0 | {5'd0, cp[20:18]}};
            step_bytes = {step_bytes, 8'h80 | {2'd0, cp[17:12]}};
            step_bytes = {step_bytes, 8'h80 | {2'd0, cp[11:6]}};
            step_bytes = {step_bytes, 8'h80 | {2'd0, cp[5:0]}};
        end
    endfunction

    // expected utf-8 results for one accepted input byte
    task automatic predict_utf8(input t_in_item it);
        logic [15:0] code_unit;
        logic        skip;
        logic        paired;
        t_out_item   r;
        int          n;
        step_bytes.delete();
        if (!byte_held) begin
            pend_byte = it.in_byte;
            byte_held = 1'b1;
        end else begin
            code_unit = order_le ? {it.in_byte, pend_byte} : {pend_byte, it.in_byte};
            byte_held = 1'b0;
            pend_byte = '0;
            skip      = 1'b0;
            if (text_fresh) begin
                text_fresh = 1'b0;
                skip       = (code_unit == BOM_UNIT);
            end
            if (!skip) begin
                paired = 1'b0;
                if (hi_waiting) begin
                    hi_waiting = 1'b0;
                    if (code_unit >= LO_SUR_MIN && code_unit <= LO_SUR_MAX) begin
                        push_code_point(SUPP_BASE + {1'b0, hi_bits, code_unit[9:0]});
                        paired = 1'b1;
                    end else begin
                        push_code_point({5'd0, HI_SUR_MIN + {6'd0, hi_bits}});
                    end
                    hi_bits = '0;
                end
                if (!paired) begin
                    if (code_unit >= HI_SUR_MIN && code_unit <= HI_SUR_MAX) begin
                        hi_bits    = code_unit[9:0];
                        hi_waiting = 1'b1;
                    end else begin
                        push_code_point({5'd0, code_unit});
                    end
                end
            end
        end
        if (it.end_of_input) begin
            if (hi_waiting) begin
                push_code_point({5'd0, HI_SUR_MIN + {6'd0, hi_bits}});
            end
            pend_byte  = '0;
            byte_held  = 1'b0;
            text_fresh = 1'b1;
            hi_bits    = '0;
            hi_waiting = 1'b0;
            if (step_bytes.size() == 0) begin
                r.out_byte    = '0;
                r.has_byte    = 1'b0;
                r.last_of_run = 1'b1;
                r.end_of_text = 1'b1;
                utf8_expected = {utf8_expected, r};
            end
        end
        n = step_bytes.size();
        for (int k = 0; k < n; k++) begin
            r.out_byte    = step_bytes[k];
            r.has_byte    = 1'b1;
            r.last_of_run = (k == n - 1);
            r.end_of_text = (k == n - 1) && it.end_of_input;
            utf8_expected = {utf8_expected, r};
        end
    endtask

    // source side: one transfer per handshake, random gaps
    always @(posedge clk) begin : drive_proc
        logic     nv;
        t_in_item ni;
        nv = in_valid;
        ni = in_item;
        if (!rst_n) begin
            nv = 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_utf8(in_item);
                nv = 1'b0;
            end
            if (!nv && utf16_bytes.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                nv = 1'b1;
                ni = utf16_bytes.pop_front();
            end
        end
        in_valid <= nv;
        in_item  <= ni;
    end

    // sink side: compare each result transfer, random back-pressure
    always @(posedge clk) begin : sink_proc
        t_out_item want;
        logic      nr;
        if (rst_n && out_valid && out_ready) begin
            if (utf8_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", out_item));
            end else begin
                want = utf8_expected.pop_front();
                if (out_item.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              out_item.out_byte, want.out_byte));
                if (out_item.has_byte !== want.has_byte)
                    report_mismatch($sformatf("has_byte %b, want %b",
                                              out_item.has_byte, want.has_byte));
                if (out_item.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              out_item.last_of_run, want.last_of_run));
                if (out_item.end_of_text !== want.end_of_text)
                    report_mismatch($sformatf("end_of_text %b, want %b",
                                              out_item.end_of_text, want.end_of_text));
            end
        end
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
        end else begin
            nr = calm || ($urandom_range(99) >= IDLE_PCT);
        end
        out_ready <= nr;
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("[utf16_to_utf8_transcoder_top] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_order(input logic le);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= le;
        order_le  = le;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic wait_drained;
        do
            @(negedge clk);
        while (utf16_bytes.size() != 0 || in_valid || utf8_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one random utf-16 text, mostly well formed, some order flips and odd tails
    task automatic add_text(input logic le, input int n_units, input bit terminate);
        logic [15:0] units [$];
        logic [7:0]  seq [$];
        logic [15:0] u;
        t_in_item    it;
        if ($urandom_range(3) == 0)
            units = {units, ($urandom_range(1) != 0) ? BOM_UNIT : 16'hFFFE};
        repeat (n_units) begin
            case ($urandom_range(9))
                0, 1: units = {units, 16'($urandom_range(16'h7F))};
                2: units = {units, 16'($urandom_range(16'h7FF, 16'h80))};
                3: units = {units, 16'($urandom_range(16'hD7FF, 16'h800))};
                4: units = {units, 16'($urandom_range(16'hFFFF, 16'hE000))};
                5, 6: begin
                    units = {units, 16'($urandom_range(16'hDBFF, 16'hD800))};
                    units = {units, 16'($urandom_range(16'hDFFF, 16'hDC00))};
                end
                7: units = {units, 16'($urandom_range(16'hDBFF, 16'hD800))};
                8: units = {units, 16'($urandom_range(16'hDFFF, 16'hDC00))};
                default: units = {units, 16'($urandom_range(16'hFFFF))};
            endcase
        end
        foreach (units[i]) begin
            u = units[i];
            if (le ^ ($urandom_range(15) == 0)) begin
                seq = {seq, u[7:0]};
                seq = {seq, u[15:8]};
            end else begin
                seq = {seq, u[15:8]};
                seq = {seq, u[7:0]};
            end
        end
        if ($urandom_range(5) == 0 || seq.size() == 0)
            seq = {seq, 8'($urandom_range(255))};
        foreach (seq[i]) begin
            it.in_byte      = seq[i];
            it.end_of_input = terminate && (i == seq.size() - 1);
            utf16_bytes     = {utf16_bytes, it};
        end
        items_queued += seq.size();
    endtask

    task automatic fill_phase(input logic le, input int target);
        items_queued = 0;
        while (items_queued < target)
            add_text(le, $urandom_range(8, 1), $urandom_range(4) != 0);
    endtask

    initial begin : stimulus
        // little-endian text: bom, 0000, 07ff, ffff, pair, lone low, high then 007f,
        // high flushed at end; then a lone odd byte that ends a text with no result bytes, only an end marker
        logic [7:0] dir_bytes [21];
        t_in_item it;
        dir_bytes = '{
            8'hFF, 8'hFE, 8'h00, 8'h00, 8'hFF, 8'h07, 8'hFF, 8'hFF,
            8'h3D, 8'hD8, 8'h00, 8'hDE, 8'h00, 8'hDC, 8'h00, 8'hD8,
            8'h7F, 8'h00, 8'hFF, 8'hDB, 8'h5A};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_bytes[i]) begin
            it.in_byte      = dir_bytes[i];
            it.end_of_input = (i >= 19);
            utf16_bytes     = {utf16_bytes, it};
        end
        wait_drained;

        // big-endian, no idling on either side; usually leave a half unit across the order change
        write_order(1'b0);
        calm = 1'b1;
        fill_phase(1'b0, 100);
        add_text(1'b0, 2, 1'b0);
        it.in_byte      = 8'($urandom_range(255));
        it.end_of_input = 1'b0;
        utf16_bytes     = {utf16_bytes, it};
        wait_drained;
        calm = 1'b0;

        // little-endian with a long sink hold-off
        write_order(1'b1);
        hold_req = 1'b1;
        fill_phase(1'b1, 160);
        wait_drained;

        write_order(1'b0);
        fill_phase(1'b0, 160);
        wait_drained;

        if (mismatches == 0) begin
            $display("[utf16_to_utf8_transcoder_top] OK");
        end else begin
            $display("[utf16_to_utf8_transcoder_top] ERROR");
        end
        $finish;
    end

endmodule
